/* rtl/core/slip_pkg.sv */
// Package for the sorted insert/pop list: command and result words,
// per-cell control word, operation and status codes. No dependencies.
package slip_pkg;

	localparam int unsigned WORD_W = 32;

	// operation codes
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_PUSH   = 2'd1;
	localparam logic [1:0] KIND_POP    = 2'd2;

	// status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]               kind;
		logic signed [WORD_W-1:0] value_in;
	} in_word_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [WORD_W-1:0] value_out;
	} out_word_t;

	// broadcast to every cell in the row
	typedef struct packed {
		logic                     ins;   // insert or push, list not full
		logic                     push;  // force position to the front
		logic                     pop;   // pop, list not empty
		logic signed [WORD_W-1:0] value;
	} cell_ctrl_t;

endpackage

/* rtl/core/slip_cell.sv */
// One slot of the ordered list: stored value plus occupied flag.
// Depends on slip_pkg (control word type, word width).
module slip_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  slip_pkg::cell_ctrl_t             ctrl,
	input  logic signed [slip_pkg::WORD_W-1:0] left_val,
	input  logic                             left_occ,
	input  logic signed [slip_pkg::WORD_W-1:0] right_val,
	input  logic                             right_occ,
	input  logic                             found_in,
	output logic                             found_out,
	output logic signed [slip_pkg::WORD_W-1:0] val,
	output logic                             occ
);

	logic signed [slip_pkg::WORD_W-1:0] val_q;
	logic                               occ_q;
	logic                               stop;

	// insert position is the first free slot or first entry >= value; push forces the front
	assign stop      = !occ_q || ctrl.push || !(val_q < ctrl.value);
	assign found_out = found_in || stop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctrl.ins) begin
			if (found_in) begin
				occ_q <= left_occ;
			end else if (stop) begin
				occ_q <= 1'b1;
			end
		end else if (ctrl.pop) begin
			occ_q <= right_occ;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (found_in) begin
				val_q <= left_val;
			end else if (stop) begin
				val_q <= ctrl.value;
			end
		end else if (ctrl.pop) begin
			val_q <= right_val;
		end
	end

	assign val = val_q;
	assign occ = occ_q;

endmodule

/* rtl/core/sorted_list_insert_pop_unit.sv */
// Top level of the sorted insert/pop list: a row of slip_cell slots and the
// result register. Depends on slip_pkg and slip_cell.
//
//  channel | ports                  | handshake
//  --------+------------------------+-------------------------------
//  command | op (kind, value_in)    | taken when start & !busy
//  result  | res (status, value_out)| valid for one cycle with done
//
// For every command all cells compare against the value at once and shift
// right (insert/push) or left (pop) on the same edge. The result word
// appears on the cycle after acceptance. busy is never raised, so a new
// command may follow every cycle. arst_n empties the list; slot contents are
// not cleared. The result side has no back-pressure.
module sorted_list_insert_pop_unit #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  slip_pkg::in_word_t  op,
	output logic                done,
	output slip_pkg::out_word_t res
);

	logic signed [slip_pkg::WORD_W-1:0] val [CAPACITY];
	logic [CAPACITY-1:0]                occ_vec;
	logic [CAPACITY:0]                  found;
	slip_pkg::cell_ctrl_t               ctrl;
	logic                               accept;
	logic                               full;
	logic                               empty;
	logic                               done_q;
	slip_pkg::out_word_t                res_q;
	slip_pkg::out_word_t                res_d;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = occ_vec[CAPACITY-1];
	assign empty  = !occ_vec[0];

	always_comb begin
		ctrl.ins   = 1'b0;
		ctrl.push  = 1'b0;
		ctrl.pop   = 1'b0;
		ctrl.value = op.value_in;
		res_d.status    = slip_pkg::ST_DONE;
		res_d.value_out = '0;
		unique case (op.kind) inside
			slip_pkg::KIND_INSERT, slip_pkg::KIND_PUSH: begin
				if (full) begin
					res_d.status = slip_pkg::ST_FULL;
				end else begin
					ctrl.ins  = accept;
					ctrl.push = (op.kind == slip_pkg::KIND_PUSH);
				end
			end
			slip_pkg::KIND_POP: begin
				if (empty) begin
					res_d.status = slip_pkg::ST_EMPTY;
				end else begin
					ctrl.pop        = accept;
					res_d.value_out = val[0];
				end
			end
			default: begin
			end
		endcase
	end

	assign found[0] = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [slip_pkg::WORD_W-1:0] lv;
		logic signed [slip_pkg::WORD_W-1:0] rv;
		logic                               lo;
		logic                               ro;
		if (i == 0) begin : g_head
			assign lv = '0;
			assign lo = 1'b0;
		end else begin : g_mid
			assign lv = val[i-1];
			assign lo = occ_vec[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign rv = '0;
			assign ro = 1'b0;
		end else begin : g_body
			assign rv = val[i+1];
			assign ro = occ_vec[i+1];
		end
		slip_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.left_val  (lv),
			.left_occ  (lo),
			.right_val (rv),
			.right_occ (ro),
			.found_in  (found[i]),
			.found_out (found[i+1]),
			.val       (val[i]),
			.occ       (occ_vec[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign done = done_q;
	assign res  = res_q;

`ifndef SYNTHESIS
	// occupied slots always form a prefix of the row
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((occ_vec >> 1) & ~occ_vec) == '0)
		else $error("occupied slots not contiguous from the front");

	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept))
		else $error("result word without accepted command");

	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ins |=> $countones(occ_vec) == $countones($past(occ_vec)) + 1)
		else $error("insert did not add exactly one entry");

	a_pop_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |=> $countones(occ_vec) + 1 == $countones($past(occ_vec)))
		else $error("pop did not remove exactly one entry");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op.kind == slip_pkg::KIND_POP && empty) |=>
		(res.status == slip_pkg::ST_EMPTY && res.value_out == '0))
		else $error("refused pop reported wrongly");
`endif

endmodule
